// ----- design/vrap_pkg.sv -----
// Shared widths, types, register codes and rounding and saturation helpers for the vertex rotator.
package vrap_pkg;

  localparam int POS_WIDTH  = 32;
  localparam int UNIT_WIDTH = 16;
  localparam int UNIT_FRAC  = UNIT_WIDTH - 2;
  localparam int TRIG_WIDTH = 2 * UNIT_WIDTH;
  localparam int CFG_WIDTH  = (POS_WIDTH > TRIG_WIDTH) ? POS_WIDTH : TRIG_WIDTH;
  localparam int CFG_IDX_W  = 3;

  // Datapath widths, each sized for the worst case of the stage that feeds it
  localparam int DIFF_W = POS_WIDTH + 2;
  localparam int KP_W   = UNIT_WIDTH + DIFF_W;
  localparam int KR_W   = KP_W - UNIT_FRAC;
  localparam int KD_W   = KR_W + 2;
  localparam int CR_W   = KR_W + 1;
  localparam int MKP_W  = UNIT_WIDTH + KD_W;
  localparam int MK_W   = MKP_W - UNIT_FRAC;
  localparam int CSP_W  = CR_W + UNIT_WIDTH;
  localparam int CS_W   = CSP_W - UNIT_FRAC;
  localparam int A1_W   = CS_W + 1;
  localparam int OMC_W  = UNIT_WIDTH + 1;
  localparam int MOP_W  = MK_W + OMC_W;
  localparam int MO_W   = MOP_W - UNIT_FRAC;
  localparam int R_W    = ((A1_W > MO_W) ? A1_W : MO_W) + 1;
  localparam int FIN_W  = R_W + 2;
  localparam int RP_W   = MOP_W;

  localparam int TURN_STAGES = 6;
  localparam int PIPE_DEPTH  = TURN_STAGES + 2;

  localparam logic signed [UNIT_WIDTH-1:0] UNIT_ONE = UNIT_WIDTH'(1) << UNIT_FRAC;
  localparam logic [TRIG_WIDTH-1:0] TRIG_RESET = {UNIT_ONE, {UNIT_WIDTH{1'b0}}};
  localparam logic signed [RP_W-1:0] RND_HALF = RP_W'(1) << (UNIT_FRAC - 1);
  localparam logic signed [RP_W-1:0] RND_LESS = RND_HALF - RP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIVOT_X = 3'd0,
    REG_PIVOT_Y = 3'd1,
    REG_PIVOT_Z = 3'd2,
    REG_AXIS_X  = 3'd3,
    REG_AXIS_Y  = 3'd4,
    REG_AXIS_Z  = 3'd5,
    REG_TRIG    = 3'd6,
    REG_MIRROR  = 3'd7
  } vrap_reg_e;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0]  pos_x;
    logic signed [POS_WIDTH-1:0]  pos_y;
    logic signed [POS_WIDTH-1:0]  pos_z;
    logic signed [UNIT_WIDTH-1:0] normal_x;
    logic signed [UNIT_WIDTH-1:0] normal_y;
    logic signed [UNIT_WIDTH-1:0] normal_z;
    logic                         normal_valid;
  } vrap_in_t;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0]  out_pos_x;
    logic signed [POS_WIDTH-1:0]  out_pos_y;
    logic signed [POS_WIDTH-1:0]  out_pos_z;
    logic signed [UNIT_WIDTH-1:0] out_normal_x;
    logic signed [UNIT_WIDTH-1:0] out_normal_y;
    logic signed [UNIT_WIDTH-1:0] out_normal_z;
    logic                         out_normal_valid;
  } vrap_out_t;

  // Drop the Q2.14 fraction bits, round to nearest with ties away from zero
  function automatic logic signed [RP_W-1:0] round_q(input logic signed [RP_W-1:0] p);
    logic signed [RP_W-1:0] b;
    b = p + (p[RP_W-1] ? RND_LESS : RND_HALF);
    return b >>> UNIT_FRAC;
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [FIN_W-1:0] v);
    logic [FIN_W-POS_WIDTH:0] hi_bits;
    hi_bits = v[FIN_W-1:POS_WIDTH-1];
    if (&hi_bits || ~|hi_bits) begin
      return v[POS_WIDTH-1:0];
    end else if (v[FIN_W-1]) begin
      return {1'b1, {(POS_WIDTH-1){1'b0}}};
    end
    return {1'b0, {(POS_WIDTH-1){1'b1}}};
  endfunction

  function automatic logic signed [UNIT_WIDTH-1:0] sat_unit(input logic signed [FIN_W-1:0] v);
    logic [FIN_W-UNIT_WIDTH:0] hi_bits;
    hi_bits = v[FIN_W-1:UNIT_WIDTH-1];
    if (&hi_bits || ~|hi_bits) begin
      return v[UNIT_WIDTH-1:0];
    end else if (v[FIN_W-1]) begin
      return {1'b1, {(UNIT_WIDTH-1){1'b0}}};
    end
    return {1'b0, {(UNIT_WIDTH-1){1'b1}}};
  endfunction

endpackage

// ----- design/vertex_rotate_about_pivot.sv -----
// Top level of the vertex rotator: configuration registers, pipeline control, output stage.
//
// Rotates one vertex per word about a unit axis through a pivot point using Rodrigues'
// formula, with the cosine and sine supplied precomputed in the trig register. Positions
// are Q16.16 and saturate on overflow; axis, cosine, sine and normals are Q2.14. A word
// whose normal_valid is low passes its normal through unchanged. In mirror-lobe mode a
// vertex with negative input x is reflected in x, rotated, and reflected back, normal
// included. The block accepts one word every clock cycle unless every stage is full and the
// output is held; each result passes through eight register stages to the output: one
// stage forms the offset from the pivot, six stages share the rotation work (products,
// rounding, dot and cross products, the one-minus-cosine term), and a final stage adds the
// pivot back, undoes the reflection and saturates into the output register. Position and
// normal each have their own multiplier pipeline. Each stage carries its own valid bit and
// stalls only when it holds a word and the stage after it is held, so bubbles collapse and
// input keeps flowing while a result waits on the output, until every stage is full. Write
// configuration only while no word is in flight; register writes take effect on the next
// clock.
module vertex_rotate_about_pivot import vrap_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vrap_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vrap_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  // Sideband that travels beside the datapath to the output stage
  typedef struct packed {
    logic                  flip;
    logic                  normal_valid;
    logic [UNIT_WIDTH-1:0] nx;
    logic [UNIT_WIDTH-1:0] ny;
    logic [UNIT_WIDTH-1:0] nz;
  } side_t;

  // Configuration registers
  logic signed [POS_WIDTH-1:0]  pivot_q [3];
  logic signed [UNIT_WIDTH-1:0] axis_q [3];
  logic [TRIG_WIDTH-1:0]        trig_q;
  logic                         mirror_q;
  logic signed [UNIT_WIDTH-1:0] cos_w, sin_w;

  // Pipeline control
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] adv;
  side_t                 side_d;
  side_t                 side_q [PIPE_DEPTH-1];

  // Stage 1 datapath
  logic signed [DIFF_W-1:0] vpos [3];
  logic signed [DIFF_W-1:0] dpos_d [3];
  logic signed [DIFF_W-1:0] dpos_q [3];
  logic signed [DIFF_W-1:0] dnrm_d [3];
  logic signed [DIFF_W-1:0] dnrm_q [3];

  // Rotation results and output stage
  logic signed [R_W-1:0]        r_pos [3];
  logic signed [R_W-1:0]        r_nrm [3];
  logic signed [FIN_W-1:0]      fin_pos [3];
  logic signed [FIN_W-1:0]      fin_nrm [3];
  logic signed [POS_WIDTH-1:0]  opos [3];
  logic signed [UNIT_WIDTH-1:0] onrm [3];
  side_t                        side_o;
  vrap_out_t                    out_d, out_q;

  assign cos_w = trig_q[TRIG_WIDTH-1:UNIT_WIDTH];
  assign sin_w = trig_q[UNIT_WIDTH-1:0];

  // Register writes; each register keeps only its own low bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q[0] <= '0;
      pivot_q[1] <= '0;
      pivot_q[2] <= '0;
      axis_q[0]  <= UNIT_ONE;
      axis_q[1]  <= '0;
      axis_q[2]  <= '0;
      trig_q     <= TRIG_RESET;
      mirror_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (vrap_reg_e'(cfg_idx_i))
        REG_PIVOT_X: pivot_q[0] <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_PIVOT_Y: pivot_q[1] <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_PIVOT_Z: pivot_q[2] <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_AXIS_X:  axis_q[0]  <= cfg_wdata_i[UNIT_WIDTH-1:0];
        REG_AXIS_Y:  axis_q[1]  <= cfg_wdata_i[UNIT_WIDTH-1:0];
        REG_AXIS_Z:  axis_q[2]  <= cfg_wdata_i[UNIT_WIDTH-1:0];
        REG_TRIG:    trig_q     <= cfg_wdata_i[TRIG_WIDTH-1:0];
        REG_MIRROR:  mirror_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_ready_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: reflect negative-x vertices in mirror mode, take the offset from the pivot
  always_comb begin
    side_d.flip         = mirror_q && in_data_i.pos_x[POS_WIDTH-1];
    side_d.normal_valid = in_data_i.normal_valid;
    side_d.nx           = in_data_i.normal_x;
    side_d.ny           = in_data_i.normal_y;
    side_d.nz           = in_data_i.normal_z;

    vpos[0] = DIFF_W'(in_data_i.pos_x);
    vpos[1] = DIFF_W'(in_data_i.pos_y);
    vpos[2] = DIFF_W'(in_data_i.pos_z);
    if (side_d.flip) begin
      vpos[0] = -vpos[0];
    end
    for (int i = 0; i < 3; i++) begin
      dpos_d[i] = vpos[i] - DIFF_W'(pivot_q[i]);
    end

    dnrm_d[0] = DIFF_W'(in_data_i.normal_x);
    dnrm_d[1] = DIFF_W'(in_data_i.normal_y);
    dnrm_d[2] = DIFF_W'(in_data_i.normal_z);
    if (side_d.flip) begin
      dnrm_d[0] = -dnrm_d[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dpos_q    <= dpos_d;
      dnrm_q    <= dnrm_d;
      side_q[0] <= side_d;
    end
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 2 to 7: the rotation proper, one pipeline for position and one for normal
  vrap_turn u_turn_pos (
    .clk_i  (clk_i),
    .en_i   (adv[TURN_STAGES:1]),
    .d_i    (dpos_q),
    .axis_i (axis_q),
    .cos_i  (cos_w),
    .sin_i  (sin_w),
    .r_o    (r_pos)
  );

  vrap_turn u_turn_nrm (
    .clk_i  (clk_i),
    .en_i   (adv[TURN_STAGES:1]),
    .d_i    (dnrm_q),
    .axis_i (axis_q),
    .cos_i  (cos_w),
    .sin_i  (sin_w),
    .r_o    (r_nrm)
  );

  // Stage 8: add the pivot back, undo the reflection, saturate
  assign side_o = side_q[PIPE_DEPTH-2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_pos[i] = FIN_W'(r_pos[i]) + FIN_W'(pivot_q[i]);
      fin_nrm[i] = FIN_W'(r_nrm[i]);
    end
    if (side_o.flip) begin
      fin_pos[0] = -fin_pos[0];
      fin_nrm[0] = -fin_nrm[0];
    end
    for (int i = 0; i < 3; i++) begin
      opos[i] = sat_pos(fin_pos[i]);
      onrm[i] = sat_unit(fin_nrm[i]);
    end

    out_d.out_pos_x        = opos[0];
    out_d.out_pos_y        = opos[1];
    out_d.out_pos_z        = opos[2];
    out_d.out_normal_valid = side_o.normal_valid;
    if (side_o.normal_valid) begin
      out_d.out_normal_x = onrm[0];
      out_d.out_normal_y = onrm[1];
      out_d.out_normal_z = onrm[2];
    end else begin
      out_d.out_normal_x = side_o.nx;
      out_d.out_normal_y = side_o.ny;
      out_d.out_normal_z = side_o.nz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[PIPE_DEPTH-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // An empty output stage opens the whole pipe
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  // An accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word not held in first stage");

  // A word leaving the last rotation stage reaches the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PIPE_DEPTH-2] && adv[PIPE_DEPTH-1] |=> out_valid_o)
    else $error("word dropped before output stage");

  // A full pipe with a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipe full and stalled");

endmodule

// ----- design/vrap_turn.sv -----
// Six-stage pipelined Rodrigues turn of one vector about the origin.
module vrap_turn import vrap_pkg::*; (
  input  logic                         clk_i,
  input  logic [TURN_STAGES-1:0]       en_i,
  input  logic signed [DIFF_W-1:0]     d_i [3],
  input  logic signed [UNIT_WIDTH-1:0] axis_i [3],
  input  logic signed [UNIT_WIDTH-1:0] cos_i,
  input  logic signed [UNIT_WIDTH-1:0] sin_i,
  output logic signed [R_W-1:0]        r_o [3]
);

  logic signed [OMC_W-1:0] omc;

  logic signed [KP_W-1:0]  s2_kp_d [3][3];
  logic signed [KP_W-1:0]  s2_kp_q [3][3];
  logic signed [KP_W-1:0]  s2_dc_d [3];
  logic signed [KP_W-1:0]  s2_dc_q [3];

  logic signed [KR_W-1:0]  s3_kr [3][3];
  logic signed [KD_W-1:0]  s3_kd_d, s3_kd_q;
  logic signed [CR_W-1:0]  s3_cr_d [3];
  logic signed [CR_W-1:0]  s3_cr_q [3];
  logic signed [KR_W-1:0]  s3_dcr_d [3];
  logic signed [KR_W-1:0]  s3_dcr_q [3];

  logic signed [MKP_W-1:0] s4_mkp_d [3];
  logic signed [MKP_W-1:0] s4_mkp_q [3];
  logic signed [CSP_W-1:0] s4_csp_d [3];
  logic signed [CSP_W-1:0] s4_csp_q [3];
  logic signed [KR_W-1:0]  s4_dcr_q [3];

  logic signed [MK_W-1:0]  s5_mk_d [3];
  logic signed [MK_W-1:0]  s5_mk_q [3];
  logic signed [A1_W-1:0]  s5_a1_d [3];
  logic signed [A1_W-1:0]  s5_a1_q [3];

  logic signed [MOP_W-1:0] s6_mop_d [3];
  logic signed [MOP_W-1:0] s6_mop_q [3];
  logic signed [A1_W-1:0]  s6_a1_q [3];

  logic signed [R_W-1:0]   s7_r_d [3];
  logic signed [R_W-1:0]   s7_r_q [3];

  assign omc = OMC_W'(UNIT_ONE) - OMC_W'(cos_i);

  // Stage 2: every axis-by-component product, and the cosine term
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s2_kp_d[j][i] = KP_W'(axis_i[j]) * KP_W'(d_i[i]);
      end
      s2_dc_d[j] = KP_W'(d_i[j]) * KP_W'(cos_i);
    end
  end

  // Stage 3: round, form the dot and cross products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s3_kr[j][i] = KR_W'(round_q(RP_W'(s2_kp_q[j][i])));
      end
      s3_dcr_d[j] = KR_W'(round_q(RP_W'(s2_dc_q[j])));
    end
    s3_kd_d    = KD_W'(s3_kr[0][0]) + KD_W'(s3_kr[1][1]) + KD_W'(s3_kr[2][2]);
    s3_cr_d[0] = CR_W'(s3_kr[1][2]) - CR_W'(s3_kr[2][1]);
    s3_cr_d[1] = CR_W'(s3_kr[2][0]) - CR_W'(s3_kr[0][2]);
    s3_cr_d[2] = CR_W'(s3_kr[0][1]) - CR_W'(s3_kr[1][0]);
  end

  // Stage 4: axis times dot product, cross product times sine
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_mkp_d[i] = MKP_W'(axis_i[i]) * MKP_W'(s3_kd_q);
      s4_csp_d[i] = CSP_W'(s3_cr_q[i]) * CSP_W'(sin_i);
    end
  end

  // Stage 5: round both, start the sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_mk_d[i] = MK_W'(round_q(RP_W'(s4_mkp_q[i])));
      s5_a1_d[i] = A1_W'(s4_dcr_q[i]) + A1_W'(CS_W'(round_q(RP_W'(s4_csp_q[i]))));
    end
  end

  // Stage 6: scale by one minus cosine
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_mop_d[i] = MOP_W'(s5_mk_q[i]) * MOP_W'(omc);
    end
  end

  // Stage 7: round and finish the sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s7_r_d[i] = R_W'(s6_a1_q[i]) + R_W'(MO_W'(round_q(RP_W'(s6_mop_q[i]))));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s2_kp_q <= s2_kp_d;
      s2_dc_q <= s2_dc_d;
    end
    if (en_i[1]) begin
      s3_kd_q  <= s3_kd_d;
      s3_cr_q  <= s3_cr_d;
      s3_dcr_q <= s3_dcr_d;
    end
    if (en_i[2]) begin
      s4_mkp_q <= s4_mkp_d;
      s4_csp_q <= s4_csp_d;
      s4_dcr_q <= s3_dcr_q;
    end
    if (en_i[3]) begin
      s5_mk_q <= s5_mk_d;
      s5_a1_q <= s5_a1_d;
    end
    if (en_i[4]) begin
      s6_mop_q <= s6_mop_d;
      s6_a1_q  <= s5_a1_q;
    end
    if (en_i[5]) begin
      s7_r_q <= s7_r_d;
    end
  end

  assign r_o = s7_r_q;

endmodule
